/* rtl/core/metronome_click_generator_defines.svh */
// Assertion shorthands for the bound checker module.
`ifndef METRONOME_CLICK_GENERATOR_DEFINES_SVH
`define METRONOME_CLICK_GENERATOR_DEFINES_SVH

// Next-cycle property, inactive while reset is held.
`define MCG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle property, inactive while reset is held.
`define MCG_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle property that also covers the reset cycles.
`define MCG_ASSERT_NEXT_RAW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/mcg_pkg.sv */
`default_nettype none

package mcg_pkg;

    localparam int REM_W      = 14;   // pulse length and remaining count
    localparam int ENV_FRAC   = 16;   // envelope fraction bits
    localparam int ENV_W      = 17;   // envelope including the value one
    localparam int SINE_W     = 15;   // quarter-wave magnitude
    localparam int CD_W       = 30;   // signed Q.8 countdown
    localparam int PERIOD_W   = 29;
    localparam int STEP_W     = 31;
    localparam int COUNT_W    = 32;
    localparam int LEVEL_W    = 16;
    localparam int BEATS_W    = 5;
    localparam int POS_W      = 4;
    localparam int CFG_DATA_W = 31;
    localparam int MUL_W      = 18;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int DIV_CNT_W  = $clog2(ENV_FRAC);

    typedef enum logic [2:0] {
        CFG_CONTROL      = 3'd0,
        CFG_PULSE_PERIOD = 3'd1,
        CFG_SUB_LOG      = 3'd2,
        CFG_BAR_BEATS    = 3'd3,
        CFG_CLICK_LEVEL  = 3'd4,
        CFG_PULSE_LENGTH = 3'd5,
        CFG_STEP_NORMAL  = 3'd6,
        CFG_STEP_ACCENT  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic             start;
        logic [REM_W-1:0] num;
        logic [REM_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [ENV_FRAC-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

/* rtl/core/mcg_sine_rom.sv */
`default_nettype none

module mcg_sine_rom #(
    parameter int ADDR_BITS = 8
) (
    input  logic                         i_clk,
    input  logic [ADDR_BITS-1:0]         i_addr,
    output logic [mcg_pkg::SINE_W-1:0]   o_data
);
    import mcg_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;
    localparam longint Q30 = 64'sd1073741824;

    // Odd polynomial in Q30 evaluated at the centre of each quarter-wave slot.
    function automatic logic [SINE_W-1:0] sine_entry(input int idx, input int tb);
        longint t;
        longint t2;
        longint p;
        longint v;
        t  = (longint'(2 * idx + 1) << 30) >>> (tb + 1);
        t2 = (t * t) / Q30;
        p  = 64'sd172272;
        p  = -64'sd5026994 + (p * t2) / Q30;
        p  = 64'sd85569306 + (p * t2) / Q30;
        p  = -64'sd693598668 + (p * t2) / Q30;
        p  = 64'sd1686629713 + (p * t2) / Q30;
        v  = (p * t) / Q30;
        v  = (v + 64'sd16384) / 64'sd32768;
        if (v < 0) begin
            v = 0;
        end
        if (v > 32767) begin
            v = 32767;
        end
        return SINE_W'(v);
    endfunction

    logic [SINE_W-1:0] w_rom [DEPTH];
    logic [SINE_W-1:0] r_data;

    for (genvar g = 0; g < DEPTH; g++) begin : g_rom
        assign w_rom[g] = sine_entry(g, ADDR_BITS);
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_rom[i_addr];
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

/* rtl/core/mcg_div.sv */
`default_nettype none

// Restoring divider for the envelope: quot = (num << ENV_FRAC) / den, num < den.
module mcg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mcg_pkg::t_div_req i_req,
    output mcg_pkg::t_div_rsp o_rsp
);
    import mcg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [REM_W-1:0]     r_rem;
    logic [REM_W-1:0]     r_den;
    logic [ENV_FRAC-1:0]  r_quot;
    logic [REM_W:0]       w_two;
    logic                 w_fit;

    assign w_two = {r_rem, 1'b0};
    assign w_fit = (w_two >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(ENV_FRAC - 1);
                r_rem  <= i_req.num;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                // one quotient bit per cycle
                r_rem  <= w_fit ? REM_W'(w_two - {1'b0, r_den}) : REM_W'(w_two);
                r_quot <= {r_quot[ENV_FRAC-2:0], w_fit};
                r_cnt  <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

`default_nettype wire

/* rtl/core/mcg_mul.sv */
`default_nettype none

// Shared signed multiplier with a registered product.
module mcg_mul (
    input  logic                               i_clk,
    input  logic signed [mcg_pkg::MUL_W-1:0]   i_a,
    input  logic signed [mcg_pkg::MUL_W-1:0]   i_b,
    output logic signed [mcg_pkg::PROD_W-1:0]  o_p
);
    import mcg_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

/* rtl/core/metronome_click_generator.sv */
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+--------------------------------------
// in       | input     | i_in_valid / o_in_ready    | i_sample_in
// out      | output    | o_out_valid / i_out_ready  | o_sample_out, o_beat_event, o_beat_total
// cfg      | input     | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_wdata
//
// One item at a time; o_in_ready is high only while the sequencer is idle.
// With clicks disabled an item goes straight to the result. Otherwise the sequencer
// updates the beat state and, while a click sounds, takes the envelope at full scale or
// from the serial envelope divider, then adds the click. Three products share one 18x18
// multiplier. The result appears as the sequencer returns to idle; the result register
// frees the input side, and a second finished item stalls until the first is taken.
// Reset (synchronous, active low) restores the register defaults and clears the metronome state.
`default_nettype none

module metronome_click_generator #(
    parameter int SAMPLE_BITS     = 16,
    parameter int SINE_TABLE_BITS = 8,
    parameter int PHASE_BITS      = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  mcg_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [mcg_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]     o_sample_out,
    output logic                              o_beat_event,
    output logic [mcg_pkg::COUNT_W-1:0]       o_beat_total
);
    import mcg_pkg::*;

    // Click scaling: the Q15 sine times a Q1.16 gain is brought down to the sample width.
    localparam int CLICK_SHIFT = 32 - SAMPLE_BITS;
    localparam int ACC_W       = 40;
    localparam int IDX_LSB     = PHASE_BITS - 2 - SINE_TABLE_BITS;
    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'((64'd1 << CLICK_SHIFT) >> 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
    localparam logic signed [CD_W:0]    CD_FLOOR = -(CD_W + 1)'(2 ** (CD_W - 1));
    localparam logic [CD_W:0]           CD_TICK  = (CD_W + 1)'(256);
    localparam logic [ENV_W-1:0]        ENV_ONE  = ENV_W'(1) << ENV_FRAC;

    // Register defaults.
    localparam logic [1:0]           RST_CONTROL = 2'd0;
    localparam logic [PERIOD_W-1:0]  RST_PERIOD  = PERIOD_W'(6144000);
    localparam logic [1:0]           RST_SUB_LOG = 2'd0;
    localparam logic [BEATS_W-1:0]   RST_BEATS   = BEATS_W'(4);
    localparam logic [LEVEL_W-1:0]   RST_LEVEL   = LEVEL_W'(65535);
    localparam logic [REM_W-1:0]     RST_LENGTH  = REM_W'(1056);
    localparam logic [STEP_W-1:0]    RST_STEP_N  = STEP_W'(98426334);
    localparam logic [STEP_W-1:0]    RST_STEP_A  = STEP_W'(157482134);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_CHECK,
        S_DIV,
        S_M1,
        S_M2,
        S_M3,
        S_ADD,
        S_TAIL,
        S_FIN
    } t_state;

    t_state r_state;

    // configuration
    logic [1:0]          r_control;
    logic [PERIOD_W-1:0] r_period;
    logic [1:0]          r_sub_log;
    logic [BEATS_W-1:0]  r_bar_beats;
    logic [LEVEL_W-1:0]  r_level;
    logic [REM_W-1:0]    r_length;
    logic [STEP_W-1:0]   r_step_n;
    logic [STEP_W-1:0]   r_step_a;

    // metronome state
    logic signed [CD_W-1:0] r_countdown;
    logic [REM_W-1:0]       r_rem;
    logic [1:0]             r_pidx;
    logic [COUNT_W-1:0]     r_beat_count;
    logic [POS_W-1:0]       r_bar_pos;
    logic                   r_seen;
    logic [PHASE_BITS-1:0]  r_phase;

    // per-item working registers
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_event;
    logic [ENV_W-1:0]              r_env;

    // result register
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample_out;
    logic                          r_beat_event;
    logic [COUNT_W-1:0]            r_beat_total;

    // Beat bookkeeping.
    logic [BEATS_W-1:0] w_beats;
    logic [1:0]         w_pmask;
    logic [BEATS_W-1:0] w_pos_inc;
    logic [POS_W-1:0]   w_bar_next;
    logic               w_cd_fire;
    logic [CD_W:0]      w_cd_add;
    logic [CD_W:0]      w_cd_sub;
    logic [CD_W-1:0]    n_countdown;
    logic               n_cd_fire;

    always_comb begin
        if (r_bar_beats == '0) begin
            w_beats = BEATS_W'(1);
        end else if (r_bar_beats > BEATS_W'(16)) begin
            w_beats = BEATS_W'(16);
        end else begin
            w_beats = r_bar_beats;
        end
        case (r_sub_log)
            2'd0:    w_pmask = 2'd0;
            2'd1:    w_pmask = 2'd1;
            default: w_pmask = 2'd3;
        endcase
    end

    assign w_pos_inc  = {1'b0, r_bar_pos} + BEATS_W'(1);
    assign w_bar_next = (w_pos_inc >= w_beats) ? '0 : w_pos_inc[POS_W-1:0];
    assign w_cd_fire  = r_countdown[CD_W-1] || (r_countdown == '0);
    assign w_cd_add   = {r_countdown[CD_W-1], r_countdown} + {2'b00, r_period};
    assign w_cd_sub   = {r_countdown[CD_W-1], r_countdown} - CD_TICK;
    // saturate the countdown so a too-short period still fires every sample
    assign n_countdown = ($signed(w_cd_sub) < CD_FLOOR) ? CD_FLOOR[CD_W-1:0]
                                                        : w_cd_sub[CD_W-1:0];
    assign n_cd_fire   = n_countdown[CD_W-1] || (n_countdown == '0);

    // Sine lookup: quadrant from the top phase bits, mirror odd quadrants.
    logic [1:0]                  w_quad;
    logic [SINE_TABLE_BITS-1:0]  w_addr;
    logic [SINE_W-1:0]           w_sine_mag;
    logic signed [MUL_W-1:0]     w_sine;

    assign w_quad = r_phase[PHASE_BITS-1 -: 2];
    assign w_addr = r_phase[IDX_LSB +: SINE_TABLE_BITS] ^ {SINE_TABLE_BITS{w_quad[0]}};

    mcg_sine_rom #(
        .ADDR_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_addr),
        .o_data (w_sine_mag)
    );

    // the phase holds from pulse start to the final add, so the ROM output is settled
    assign w_sine = w_quad[1] ? -$signed({3'b000, w_sine_mag}) : $signed({3'b000, w_sine_mag});

    // Envelope divider.
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    assign w_div_req.start = (r_state == S_CHECK) && (r_rem != '0) && (r_rem < r_length);
    assign w_div_req.num   = r_rem;
    assign w_div_req.den   = r_length;

    mcg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Shared multiplier: env*env, then env2*level, then sine*gain.
    logic [ENV_W-1:0]         w_lvl;
    logic [ENV_W-1:0]         w_hi17;
    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_prod;

    assign w_lvl  = {1'b0, r_level} + ENV_W'(r_level[LEVEL_W-1]);
    assign w_hi17 = w_prod[ENV_FRAC +: ENV_W];

    always_comb begin
        case (r_state)
            S_M1: begin
                w_mul_a = $signed({1'b0, r_env});
                w_mul_b = $signed({1'b0, r_env});
            end
            S_M2: begin
                w_mul_a = $signed({1'b0, w_hi17});
                w_mul_b = $signed({1'b0, w_lvl});
            end
            S_M3: begin
                w_mul_a = w_sine;
                w_mul_b = $signed({1'b0, w_hi17});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    mcg_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // Round half up, add to the sample and saturate.
    logic signed [ACC_W-1:0]       w_click;
    logic signed [ACC_W-1:0]       w_sum;
    logic signed [SAMPLE_BITS-1:0] n_x;
    logic                          w_accent;
    logic [STEP_W-1:0]             w_step;

    assign w_click = (ACC_W'(w_prod) + HALF) >>> CLICK_SHIFT;
    assign w_sum   = ACC_W'(r_x) + w_click;

    always_comb begin
        if (w_sum > SAT_HI) begin
            n_x = SAT_HI[SAMPLE_BITS-1:0];
        end else if (w_sum < SAT_LO) begin
            n_x = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            n_x = w_sum[SAMPLE_BITS-1:0];
        end
    end

    // accent on the first beat of each bar, once any beat has been seen
    assign w_accent = r_control[1] && r_seen && (r_bar_pos == '0);
    assign w_step   = w_accent ? r_step_a : r_step_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_control    <= RST_CONTROL;
            r_period     <= RST_PERIOD;
            r_sub_log    <= RST_SUB_LOG;
            r_bar_beats  <= RST_BEATS;
            r_level      <= RST_LEVEL;
            r_length     <= RST_LENGTH;
            r_step_n     <= RST_STEP_N;
            r_step_a     <= RST_STEP_A;
            r_countdown  <= '0;
            r_rem        <= '0;
            r_pidx       <= '0;
            r_beat_count <= '0;
            r_bar_pos    <= '0;
            r_seen       <= 1'b0;
            r_phase      <= '0;
            r_event      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CONTROL:      r_control   <= i_cfg_wdata[1:0];
                    CFG_PULSE_PERIOD: r_period    <= i_cfg_wdata[PERIOD_W-1:0];
                    CFG_SUB_LOG:      r_sub_log   <= i_cfg_wdata[1:0];
                    CFG_BAR_BEATS:    r_bar_beats <= i_cfg_wdata[BEATS_W-1:0];
                    CFG_CLICK_LEVEL:  r_level     <= i_cfg_wdata[LEVEL_W-1:0];
                    CFG_PULSE_LENGTH: r_length    <= i_cfg_wdata[REM_W-1:0];
                    CFG_STEP_NORMAL:  r_step_n    <= i_cfg_wdata[STEP_W-1:0];
                    CFG_STEP_ACCENT:  r_step_a    <= i_cfg_wdata[STEP_W-1:0];
                endcase
            end

            // drop the result once taken, unless the next one is loaded below
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x     <= i_sample_in;
                        r_event <= 1'b0;
                        // disabled: pass the sample, hold all state
                        r_state <= r_control[0] ? S_START : S_FIN;
                    end
                end
                S_START: begin
                    if (w_cd_fire) begin
                        if ((r_pidx & w_pmask) == 2'd0) begin
                            r_beat_count <= r_beat_count + COUNT_W'(1);
                            r_event      <= 1'b1;
                            if (!r_seen) begin
                                r_bar_pos <= '0;
                                r_seen    <= 1'b1;
                            end else begin
                                r_bar_pos <= w_bar_next;
                            end
                        end
                        r_rem       <= r_length;
                        r_phase     <= '0;
                        r_countdown <= w_cd_add[CD_W-1:0];
                    end
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_rem == '0) begin
                        r_state <= S_TAIL;
                    end else if (r_rem >= r_length) begin
                        // envelope held at one, skip the divider
                        r_env   <= ENV_ONE;
                        r_state <= S_M1;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_env   <= {1'b0, w_div_rsp.quot};
                        r_state <= S_M1;
                    end
                end
                S_M1: r_state <= S_M2;
                S_M2: r_state <= S_M3;
                S_M3: r_state <= S_ADD;
                S_ADD: begin
                    r_x     <= n_x;
                    r_phase <= r_phase + PHASE_BITS'(w_step);
                    r_rem   <= r_rem - REM_W'(1);
                    r_state <= S_TAIL;
                end
                S_TAIL: begin
                    r_countdown <= n_countdown;
                    if (n_cd_fire) begin
                        r_pidx <= r_pidx + 2'd1;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // wait for the result register to be free
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_sample_out <= r_x;
                        r_beat_event <= r_event;
                        r_beat_total <= r_beat_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_beat_event = r_beat_event;
    assign o_beat_total = r_beat_total;

endmodule

`default_nettype wire

/* rtl/core/mcg_checker.sv */
`default_nettype none
`include "metronome_click_generator_defines.svh"

module mcg_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [SAMPLE_BITS-1:0]        o_sample_out,
    input logic                          o_beat_event,
    input logic [mcg_pkg::COUNT_W-1:0]   o_beat_total
);
    import mcg_pkg::*;

    logic               r_have;
    logic [COUNT_W-1:0] r_last_total;

    // track the beat total of the last item delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            r_have       <= 1'b1;
            r_last_total <= o_beat_total;
        end
    end

    `MCG_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_sample_out) && $stable(o_beat_event) && $stable(o_beat_total), "result changed while stalled")
    `MCG_ASSERT_IMPL(a_total_step, o_out_valid && i_out_ready && r_have, o_beat_total == r_last_total + COUNT_W'(o_beat_event), "beat total did not follow beat event")
    `MCG_ASSERT_NEXT(a_one_item, i_in_valid && o_in_ready, !o_in_ready, "second item taken while busy")
    `MCG_ASSERT_NEXT_RAW(a_reset, !i_rst_n, !o_out_valid && o_in_ready, "block not idle after reset")

endmodule

bind metronome_click_generator mcg_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (.*);

`default_nettype wire

/* tb/mcg_click_checker.sv */
`timescale 1ns / 100ps

module mcg_click_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  mcg_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [mcg_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic signed [15:0]             i_sample_in,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic signed [15:0]             i_sample_out,
    input  logic                           i_beat_event,
    input  logic [mcg_pkg::COUNT_W-1:0]    i_beat_total,
    output int                             o_fail_count,
    output int                             o_pending
);
    import mcg_pkg::*;

    localparam longint SINE_Q30 = 64'sd1073741824;
    localparam longint CD_MIN   = -64'sd536870912;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               beat;
        logic [31:0]        total;
    } click_result_t;

    logic [14:0] quarter_sine [0:255];

    // register copies
    logic [1:0]  reg_control;
    logic [28:0] reg_period;
    logic [1:0]  reg_sub_log;
    logic [4:0]  reg_bar_beats;
    logic [15:0] reg_level;
    logic [13:0] reg_length;
    logic [30:0] reg_step_normal;
    logic [30:0] reg_step_accent;

    // click state
    longint      countdown;
    logic [13:0] pulse_left;
    logic [1:0]  pulse_idx;
    logic [31:0] beat_cnt;
    logic [3:0]  bar_pos;
    logic        beat_seen;
    logic [31:0] tone_phase;

    click_result_t expected_clicks[$];

    // Odd polynomial in Q30, truncating products, rounded to Q15.
    function automatic int quarter_sine_entry(input int i);
        longint t, t2, p, v;
        t  = (longint'(2 * i + 1) << 30) / 512;
        t2 = (t * t) / SINE_Q30;
        p  = 172272;
        p  = -5026994 + (p * t2) / SINE_Q30;
        p  = 85569306 + (p * t2) / SINE_Q30;
        p  = -693598668 + (p * t2) / SINE_Q30;
        p  = 1686629713 + (p * t2) / SINE_Q30;
        v  = (p * t) / SINE_Q30;
        v  = (v + 16384) / 32768;
        if (v < 0) v = 0;
        if (v > 32767) v = 32767;
        return int'(v);
    endfunction

    function automatic longint sine_value(input logic [31:0] ph);
        logic [7:0] idx;
        longint     s;
        idx = ph[29:22];
        if (ph[30]) idx = 8'd255 - idx;
        s = longint'(quarter_sine[idx]);
        return ph[31] ? -s : s;
    endfunction

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task automatic predict_click(input logic signed [15:0] smp, output click_result_t res);
        longint     x, env, env2, lvl, gain, prod;
        int         nbeats, nxt;
        logic [1:0] pmask;
        logic       accent;
        logic       beat_flag;
        x = longint'(smp);
        beat_flag = 1'b0;
        if (reg_control[0]) begin
            nbeats = (reg_bar_beats == 0) ? 1 : ((reg_bar_beats > 16) ? 16 : int'(reg_bar_beats));
            pmask  = (reg_sub_log == 0) ? 2'd0 : ((reg_sub_log == 1) ? 2'd1 : 2'd3);
            if (countdown <= 0) begin
                if ((pulse_idx & pmask) == 2'd0) begin
                    beat_cnt  = beat_cnt + 1;
                    beat_flag = 1'b1;
                    if (!beat_seen) begin
                        bar_pos   = 4'd0;
                        beat_seen = 1'b1;
                    end else begin
                        nxt     = int'(bar_pos) + 1;
                        bar_pos = (nxt >= nbeats) ? 4'd0 : nxt[3:0];
                    end
                end
                pulse_left = reg_length;
                tone_phase = '0;
                countdown  = countdown + longint'(reg_period);
            end
            if (pulse_left != 0) begin
                accent = reg_control[1] && beat_seen && (bar_pos == 4'd0);
                if (pulse_left >= reg_length)
                    env = 65536;
                else
                    env = (longint'(pulse_left) << 16) / longint'(reg_length);
                env2 = (env * env) >>> 16;
                lvl  = longint'(reg_level) + longint'(reg_level >> 15);
                gain = (env2 * lvl) >>> 16;
                prod = sine_value(tone_phase) * gain + 32768;
                x    = x + (prod >>> 16);
                if (x > 32767) x = 32767;
                if (x < -32768) x = -32768;
                tone_phase = tone_phase + (accent ? {1'b0, reg_step_accent}
                                                  : {1'b0, reg_step_normal});
                pulse_left = pulse_left - 1'b1;
            end
            countdown = countdown - 256;
            if (countdown < CD_MIN) countdown = CD_MIN;
            if (countdown <= 0) pulse_idx = pulse_idx + 1'b1;
        end
        res.sample = x[15:0];
        res.beat   = beat_flag;
        res.total  = beat_cnt;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        for (int i = 0; i < 256; i++) quarter_sine[i] = 15'(quarter_sine_entry(i));
    end

    always @(posedge i_clk) begin : watch
        click_result_t want;
        if (!i_rst_n) begin
            reg_control     = 2'd0;
            reg_period      = 29'd6144000;
            reg_sub_log     = 2'd0;
            reg_bar_beats   = 5'd4;
            reg_level       = 16'd65535;
            reg_length      = 14'd1056;
            reg_step_normal = 31'd98426334;
            reg_step_accent = 31'd157482134;
            countdown       = 0;
            pulse_left      = '0;
            pulse_idx       = '0;
            beat_cnt        = '0;
            bar_pos         = '0;
            beat_seen       = 1'b0;
            tone_phase      = '0;
            expected_clicks.delete();
        end else begin
            // compare first: a result never belongs to the item taken at the same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_clicks.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no sample pending",
                                              i_sample_out));
                end else begin
                    want = expected_clicks.pop_front();
                    if (i_sample_out !== want.sample)
                        report_mismatch($sformatf("sample_out got %0d want %0d",
                                                  i_sample_out, want.sample));
                    if (i_beat_event !== want.beat)
                        report_mismatch($sformatf("beat_event got %0b want %0b",
                                                  i_beat_event, want.beat));
                    if (i_beat_total !== want.total)
                        report_mismatch($sformatf("beat_total got %0d want %0d",
                                                  i_beat_total, want.total));
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_click(i_sample_in, want);
                expected_clicks.push_back(want);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CONTROL:      reg_control     = i_cfg_wdata[1:0];
                    CFG_PULSE_PERIOD: reg_period      = i_cfg_wdata[28:0];
                    CFG_SUB_LOG:      reg_sub_log     = i_cfg_wdata[1:0];
                    CFG_BAR_BEATS:    reg_bar_beats   = i_cfg_wdata[4:0];
                    CFG_CLICK_LEVEL:  reg_level       = i_cfg_wdata[15:0];
                    CFG_PULSE_LENGTH: reg_length      = i_cfg_wdata[13:0];
                    CFG_STEP_NORMAL:  reg_step_normal = i_cfg_wdata[30:0];
                    CFG_STEP_ACCENT:  reg_step_accent = i_cfg_wdata[30:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_clicks.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import mcg_pkg::*;

    // Quiet cycles (nothing taken on either channel) before the run is abandoned.
    // Worst honest gap: the receiver hold-off plus a decaying click plus a long random
    // sender gap, which the limit covers with ample margin.
    localparam int QUIET_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 1850;
    localparam int HOLD_CYCLES  = 400;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    t_cfg_idx              cfg_idx   = CFG_CONTROL;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic signed [15:0]    sample_in = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [15:0]    sample_out;
    logic                  beat_event;
    logic [COUNT_W-1:0]    beat_total;

    int   fail_count;
    int   pending;
    int   sent_cnt = 0;
    logic calm;

    // Stretch with no idling on either side, in the middle of the random part.
    assign calm = (sent_cnt >= 600) && (sent_cnt < 900);

    always #5 clk = ~clk;

    metronome_click_generator u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_sample_in  (sample_in),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_sample_out (sample_out),
        .o_beat_event (beat_event),
        .o_beat_total (beat_total)
    );

    mcg_click_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_sample_in  (sample_in),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_sample_out (sample_out),
        .i_beat_event (beat_event),
        .i_beat_total (beat_total),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one sample: idle a random number of cycles first, then hold valid and
    // the payload steady until the block takes the item. Entered and left at a
    // falling edge.
    task automatic send_sample(input logic signed [15:0] s);
        while (!calm && $urandom_range(0, 99) < 34) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= s;
        do @(posedge clk); while (!in_ready);
        sent_cnt++;
        @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= d;
        @(negedge clk);
    endtask

    // Drop valid, wait until every result has been taken, then rewrite all
    // eight registers back to back.
    task automatic configure(input logic [1:0] ctl, input logic [28:0] period,
                             input logic [1:0] sub, input logic [4:0] beats,
                             input logic [15:0] level, input logic [13:0] plen,
                             input logic [30:0] stn, input logic [30:0] sta);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        write_reg(CFG_CONTROL,      CFG_DATA_W'(ctl));
        write_reg(CFG_PULSE_PERIOD, CFG_DATA_W'(period));
        write_reg(CFG_SUB_LOG,      CFG_DATA_W'(sub));
        write_reg(CFG_BAR_BEATS,    CFG_DATA_W'(beats));
        write_reg(CFG_CLICK_LEVEL,  CFG_DATA_W'(level));
        write_reg(CFG_PULSE_LENGTH, CFG_DATA_W'(plen));
        write_reg(CFG_STEP_NORMAL,  CFG_DATA_W'(stn));
        write_reg(CFG_STEP_ACCENT,  CFG_DATA_W'(sta));
        cfg_we <= 1'b0;
    endtask

    // Mostly full-range audio, with a fair share of rails and near-rail values
    // so that the click pushes the sum into saturation.
    function automatic logic signed [15:0] random_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 16'($urandom);
        if (r < 70) return (r[0]) ? 16'sh7FFF : 16'sh8000;
        if (r < 75) return 16'($urandom_range(0, 2)) - 16'sd1;
        if (r < 90) begin
            if (r[0]) return 16'(32767 - $urandom_range(0, 2000));
            return 16'(-32768 + $urandom_range(0, 2000));
        end
        return 16'($urandom_range(0, 200)) - 16'sd100;
    endfunction

    function automatic logic [30:0] random_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 31'h7FFF_FFFF;
        if (r < 15) return 31'd0;
        return 31'($urandom);
    endfunction

    // Receiver: ready at random, with stretches of full throughput, and twice a
    // long hold-off while the sender keeps offering, so the result register fills
    // and the block stalls its input.
    initial begin : receiver
        int hold_left;
        int next_hold_at;
        hold_left    = 0;
        next_hold_at = 300;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (sent_cnt >= next_hold_at && next_hold_at < 2000) begin
                out_ready <= 1'b0;
                hold_left = HOLD_CYCLES;
                next_hold_at += 900;
            end else begin
                out_ready <= calm || ($urandom_range(0, 99) >= 34);
            end
        end
    end

    // Watchdog: abandon the run once nothing has moved for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial begin : stimulus
        int          n;
        int          r;
        int          random_sent;
        logic [1:0]  ctl;
        logic [28:0] period;
        logic [1:0]  sub;
        logic [4:0]  beats;
        logic [15:0] level;
        logic [13:0] plen;

        // Hold reset, then release it on a falling edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Disabled after reset: samples pass untouched.
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);

        // Period of zero (a pulse every sample), subdivision code 3, bar beats 0,
        // pulse length zero so the pulses are silent.
        configure(2'd3, 29'd0, 2'd3, 5'd0, 16'hFFFF, 14'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_sample(16'sd1234);
        send_sample(-16'sd1);
        send_sample(16'sh7FFF);

        // Short audible pulses with accent, bar beats above 16, hard saturation.
        configure(2'd3, 29'd640, 2'd1, 5'd17, 16'hFFFF, 14'd12, 31'h7FFF_FFFF, 31'd0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sd30000);
        send_sample(-16'sd30000);
        send_sample(16'sd0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sd5);

        // Shrink the length while a pulse is still sounding (envelope held at
        // full scale), with the longest period and the accent switched off.
        configure(2'd1, 29'h1FFF_FFFF, 2'd2, 5'd1, 16'd40000, 14'd3,
                  31'd98426334, 31'd157482134);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sd100);
        send_sample(-16'sd100);

        // Period below one sample, longest pulse, silent level, full bar.
        configure(2'd3, 29'd100, 2'd0, 5'd16, 16'd0, 14'h3FFF, 31'd12345678, 31'h7FFF_FFFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        send_sample(16'sd1);

        // Random phases: fresh settings, then a burst of random audio. Periods are
        // kept short mostly so that pulses and beats come often.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            r   = $urandom_range(0, 99);
            ctl = (r < 10) ? 2'd0 : (r < 20) ? 2'd2 : (r < 55) ? 2'd1 : 2'd3;
            r   = $urandom_range(0, 99);
            if (r < 8)
                period = 29'($urandom_range(0, 255));
            else if (r < 11)
                period = 29'h1FFF_FFFF;
            else
                period = 29'($urandom_range(256, 256 * 48));
            sub = 2'($urandom_range(0, 3));
            r   = $urandom_range(0, 99);
            beats = (r < 15) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16));
            r   = $urandom_range(0, 99);
            level = (r < 10) ? 16'hFFFF : (r < 15) ? 16'd0 : (r < 20) ? 16'h8000
                                        : 16'($urandom);
            r   = $urandom_range(0, 99);
            if (r < 5)
                plen = 14'd0;
            else if (r < 10)
                plen = 14'($urandom_range(64, 16383));
            else if (r < 15)
                plen = 14'h3FFF;
            else
                plen = 14'($urandom_range(1, 48));
            configure(ctl, period, sub, beats, level, plen, random_step(), random_step());
            n = $urandom_range(30, 160);
            for (int k = 0; k < n && random_sent < RANDOM_ITEMS; k++) begin
                send_sample(random_sample());
                random_sent++;
            end
        end

        // Drain: wait for every result, then let the block settle.
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
